[hdl/infix_expression_evaluator_unit_defines.svh]
// ---------------------------------------------------------------------------
// infix expression evaluator assertion macros
// shared property wrappers for the evaluator rtl
// ---------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define IEE_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: %m");
// next-cycle implication, disabled during reset
`define IEE_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: %m");
`else
`define IEE_ASSERT_IMPLY(label, clk, rst, a, c)
`define IEE_ASSERT_NEXT(label, clk, rst, a, c)
`endif

`endif

[hdl/iee_pkg.sv]
// ---------------------------------------------------------------------------
// iee_pkg
// shared codes, types and helpers of the infix expression evaluator
// ---------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

  localparam int DEF_STACK_DEPTH = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int CMD_W    = 2;
  localparam int NUM_W    = 31;
  localparam int OP_W     = 3;
  localparam int RESULT_W = 32;
  localparam int STATUS_W = 3;

  // token kinds
  localparam logic [CMD_W-1:0] CMD_NUM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END = 2'd2;

  // operator codes
  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
  localparam logic [OP_W-1:0] OP_MOD   = 3'd4;
  localparam logic [OP_W-1:0] OP_OPEN  = 3'd5;
  localparam logic [OP_W-1:0] OP_CLOSE = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAREN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDER    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OP_RD,
    S_OP_WT,
    S_VB_RD,
    S_VA_RD,
    S_VA_LAT,
    S_ALU,
    S_FIN_RD,
    S_FIN_WT
  } seq_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV
  } alu_state_t;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic divzero;
  } alu_rsp_t;

  // first error wins
  function automatic logic [STATUS_W-1:0] note_err(input logic [STATUS_W-1:0] cur,
                                                   input logic [STATUS_W-1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

`default_nettype wire

[hdl/iee_in_if.sv]
// ---------------------------------------------------------------------------
// iee_in_if
// token channel: valid, ready and one token
// ---------------------------------------------------------------------------
`default_nettype none

interface iee_in_if;
  import iee_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [NUM_W-1:0] number_value;
  logic [OP_W-1:0]  op_code;

  modport source (output valid, output cmd, output number_value, output op_code,
                  input ready);
  modport sink   (input valid, input cmd, input number_value, input op_code,
                  output ready);
endinterface

`default_nettype wire

[hdl/iee_out_if.sv]
// ---------------------------------------------------------------------------
// iee_out_if
// result channel: valid, ready, value and status
// ---------------------------------------------------------------------------
`default_nettype none

interface iee_out_if;
  import iee_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

`default_nettype wire

[hdl/iee_ram.sv]
// ---------------------------------------------------------------------------
// iee_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module iee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/iee_alu.sv]
// ---------------------------------------------------------------------------
// iee_alu
// shared arithmetic unit: registered add/sub, shift-add multiply and
// restoring divide or modulo one bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module iee_alu #(
  parameter int VALUE_WIDTH = iee_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire iee_pkg::alu_req_t      req,
  input  wire logic [VALUE_WIDTH-1:0] a,
  input  wire logic [VALUE_WIDTH-1:0] b,
  output iee_pkg::alu_rsp_t           rsp,
  output logic      [VALUE_WIDTH-1:0] res
);
  import iee_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int CW  = $clog2(W);

  alu_state_t     state, state_next;
  logic [W-1:0]   acc, acc_next;
  logic [W-1:0]   mc, mc_next;
  logic [W-1:0]   quo, quo_next;
  logic [W-1:0]   rem, rem_next;
  logic [W-1:0]   dvs, dvs_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic           neg_q, neg_q_next;
  logic           neg_r, neg_r_next;
  logic           is_mod, is_mod_next;
  logic [W-1:0]   res_next;
  logic           done, done_next;
  logic           dz, dz_next;

  logic [W-1:0]   ma, mb, acc_sum, q_fin, r_fin;
  logic [W:0]     rem_sh, diff;
  logic           qbit;

  always_comb begin
    state_next  = state;
    acc_next    = acc;
    mc_next     = mc;
    quo_next    = quo;
    rem_next    = rem;
    dvs_next    = dvs;
    cnt_next    = cnt;
    neg_q_next  = neg_q;
    neg_r_next  = neg_r;
    is_mod_next = is_mod;
    res_next    = res;
    done_next   = 1'b0;
    dz_next     = 1'b0;

    ma      = a[W-1] ? (W'(0) - a) : a;
    mb      = b[W-1] ? (W'(0) - b) : b;
    acc_sum = acc + (quo[0] ? mc : W'(0));
    rem_sh  = {rem, quo[W-1]};
    diff    = rem_sh - {1'b0, dvs};
    qbit    = !diff[W];
    q_fin   = {quo[W-2:0], qbit};
    r_fin   = qbit ? diff[W-1:0] : rem_sh[W-1:0];

    case (state)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_ADD: begin
              res_next  = a + b;
              done_next = 1'b1;
            end
            OP_SUB: begin
              res_next  = a - b;
              done_next = 1'b1;
            end
            OP_MUL: begin
              // multiplier bits shift through quo
              acc_next   = '0;
              mc_next    = a;
              quo_next   = b;
              cnt_next   = CW'(W - 1);
              state_next = A_MUL;
            end
            default: begin
              if (mb == '0) begin
                res_next  = '0;
                dz_next   = 1'b1;
                done_next = 1'b1;
              end else begin
                quo_next    = ma;
                rem_next    = '0;
                dvs_next    = mb;
                neg_q_next  = a[W-1] ^ b[W-1];
                neg_r_next  = a[W-1];
                is_mod_next = (req.op == OP_MOD);
                cnt_next    = CW'(W - 1);
                state_next  = A_DIV;
              end
            end
          endcase
        end
      end
      A_MUL: begin
        acc_next = acc_sum;
        mc_next  = {mc[W-2:0], 1'b0};
        quo_next = {1'b0, quo[W-1:1]};
        cnt_next = cnt - CW'(1);
        if (cnt == '0) begin
          res_next   = acc_sum;
          done_next  = 1'b1;
          state_next = A_IDLE;
        end
      end
      A_DIV: begin
        rem_next = r_fin;
        quo_next = q_fin;
        cnt_next = cnt - CW'(1);
        if (cnt == '0) begin
          if (is_mod) begin
            res_next = neg_r ? (W'(0) - r_fin) : r_fin;
          end else begin
            res_next = neg_q ? (W'(0) - q_fin) : q_fin;
          end
          done_next  = 1'b1;
          state_next = A_IDLE;
        end
      end
      default: state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
      dz    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      dz    <= dz_next;
    end
    acc    <= acc_next;
    mc     <= mc_next;
    quo    <= quo_next;
    rem    <= rem_next;
    dvs    <= dvs_next;
    cnt    <= cnt_next;
    neg_q  <= neg_q_next;
    neg_r  <= neg_r_next;
    is_mod <= is_mod_next;
    res    <= res_next;
  end

  assign rsp.done    = done;
  assign rsp.divzero = dz;

endmodule

`default_nettype wire

[hdl/infix_expression_evaluator_unit.sv]
// ---------------------------------------------------------------------------
// infix_expression_evaluator_unit
// two-stack infix evaluator: tokens in, one value and status per expression
// ---------------------------------------------------------------------------
// usage
//   tok: token channel (cmd, number_value, op_code), transfer on valid & ready
//   res: result channel (result, status), transfer on valid & ready
//   a number or an open paren is taken straight from idle and ready stays high
//   other operators walk the operator stack, reading its top entry, and each
//   add/sub, multiply, divide or modulo reduction runs through one shared
//   arithmetic unit
//   end of expression reduces everything, then reads the single value
//   and loads the output register
//   ready is low while a token is being worked on
//   the result register holds while the receiver stalls; new tokens are still
//   taken, and only a second end of expression waits for the old transfer
//   reset (rst, synchronous) empties both stacks and clears the error code;
//   stack contents need no clearing since nothing above a count is read
//   errors are sticky and reported only with the end result
// ---------------------------------------------------------------------------
`default_nettype none
`include "infix_expression_evaluator_unit_defines.svh"

module infix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = iee_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = iee_pkg::DEF_VALUE_WIDTH
) (
  input wire logic clk,
  input wire logic rst,
  iee_in_if.sink   tok,
  iee_out_if.source res
);
  import iee_pkg::*;

  localparam int W      = VALUE_WIDTH;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  // sequencer state and stack counts
  seq_state_t           state, state_next;
  logic [CNT_W-1:0]     ocnt, ocnt_next;
  logic [CNT_W-1:0]     vcnt, vcnt_next;
  logic [STATUS_W-1:0]  err, err_next;
  logic [OP_W-1:0]      tok_op, tok_op_next;
  logic                 tok_end, tok_end_next;
  logic [W-1:0]         b_reg, b_reg_next;

  // output register
  logic                       out_valid, out_valid_next;
  logic signed [RESULT_W-1:0] out_result, out_result_next;
  logic [STATUS_W-1:0]        out_status, out_status_next;

  // stack memories
  logic              o_we, v_we;
  logic [ADDR_W-1:0] o_waddr, o_raddr, v_waddr, v_raddr;
  logic [OP_W-1:0]   o_wdata, o_rdata;
  logic [W-1:0]      v_wdata, v_rdata;

  // arithmetic unit
  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [W-1:0] alu_res;

  logic [CNT_W-1:0]    ocnt_m1, vcnt_m1, vcnt_m2;
  logic                tok_fire, fin_fire, reduce;
  logic [STATUS_W-1:0] fin_err;

  assign ocnt_m1  = ocnt - CNT_W'(1);
  assign vcnt_m1  = vcnt - CNT_W'(1);
  assign vcnt_m2  = vcnt - CNT_W'(2);
  assign tok_fire = tok.valid && tok.ready;
  assign fin_fire = (state == S_FIN_WT) && (!out_valid || res.ready);

  // final status folds in the value count check
  always_comb begin
    fin_err = err;
    if (vcnt == '0) begin
      fin_err = note_err(err, ST_UNDER);
    end else if (vcnt > CNT_W'(1)) begin
      fin_err = note_err(err, ST_LEFTOVER);
    end
  end

  // does the operator on top have to be reduced before this token
  always_comb begin
    if (tok_end) begin
      reduce = 1'b1;
    end else begin
      case (tok_op)
        OP_ADD, OP_SUB: reduce = (o_rdata <= OP_MOD);
        OP_CLOSE:       reduce = (o_rdata != OP_OPEN);
        default:        reduce = (o_rdata == OP_MUL) || (o_rdata == OP_DIV) ||
                                 (o_rdata == OP_MOD);
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    ocnt_next       = ocnt;
    vcnt_next       = vcnt;
    err_next        = err;
    tok_op_next     = tok_op;
    tok_end_next    = tok_end;
    b_reg_next      = b_reg;
    out_valid_next  = out_valid && !res.ready;
    out_result_next = out_result;
    out_status_next = out_status;

    o_we    = 1'b0;
    o_waddr = ocnt[ADDR_W-1:0];
    o_wdata = tok_op;
    o_raddr = ocnt_m1[ADDR_W-1:0];
    v_we    = 1'b0;
    v_waddr = vcnt[ADDR_W-1:0];
    v_wdata = W'(tok.number_value);
    v_raddr = vcnt_m1[ADDR_W-1:0];

    alu_req.start = 1'b0;
    alu_req.op    = o_rdata;

    case (state)
      S_IDLE: begin
        if (tok_fire) begin
          case (tok.cmd)
            CMD_NUM: begin
              if (vcnt >= CNT_W'(STACK_DEPTH)) begin
                err_next = note_err(err, ST_OVER);
              end else begin
                v_we      = 1'b1;
                vcnt_next = vcnt + CNT_W'(1);
              end
            end
            CMD_OP: begin
              if (tok.op_code == OP_OPEN) begin
                o_wdata = tok.op_code;
                if (ocnt >= CNT_W'(STACK_DEPTH)) begin
                  err_next = note_err(err, ST_OVER);
                end else begin
                  o_we      = 1'b1;
                  ocnt_next = ocnt + CNT_W'(1);
                end
              end else if (tok.op_code <= OP_MOD || tok.op_code == OP_CLOSE) begin
                tok_op_next  = tok.op_code;
                tok_end_next = 1'b0;
                state_next   = S_OP_RD;
              end
            end
            CMD_END: begin
              tok_end_next = 1'b1;
              state_next   = S_OP_RD;
            end
            default: ;
          endcase
        end
      end
      S_OP_RD: begin
        // read address of the top entry is already on the port
        if (ocnt == '0) begin
          if (tok_end) begin
            state_next = S_FIN_RD;
          end else if (tok_op == OP_CLOSE) begin
            err_next   = note_err(err, ST_PAREN);
            state_next = S_IDLE;
          end else begin
            o_we       = 1'b1;
            ocnt_next  = ocnt + CNT_W'(1);
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_OP_WT;
        end
      end
      S_OP_WT: begin
        if (!tok_end && tok_op == OP_CLOSE && o_rdata == OP_OPEN) begin
          // matching open paren is dropped
          ocnt_next  = ocnt_m1;
          state_next = S_IDLE;
        end else if (reduce) begin
          ocnt_next = ocnt_m1;
          if (o_rdata == OP_OPEN) begin
            state_next = S_OP_RD;
          end else if (vcnt < CNT_W'(2)) begin
            err_next   = note_err(err, ST_UNDER);
            state_next = S_OP_RD;
          end else begin
            state_next = S_VB_RD;
          end
        end else begin
          if (ocnt >= CNT_W'(STACK_DEPTH)) begin
            err_next = note_err(err, ST_OVER);
          end else begin
            o_we      = 1'b1;
            ocnt_next = ocnt + CNT_W'(1);
          end
          state_next = S_IDLE;
        end
      end
      S_VB_RD: begin
        // operator entry just above the count still holds the popped op
        o_raddr    = ocnt[ADDR_W-1:0];
        v_raddr    = vcnt_m1[ADDR_W-1:0];
        state_next = S_VA_RD;
      end
      S_VA_RD: begin
        o_raddr    = ocnt[ADDR_W-1:0];
        b_reg_next = v_rdata;
        v_raddr    = vcnt_m2[ADDR_W-1:0];
        state_next = S_VA_LAT;
      end
      S_VA_LAT: begin
        o_raddr       = ocnt[ADDR_W-1:0];
        alu_req.start = 1'b1;
        alu_req.op    = o_rdata;
        state_next    = S_ALU;
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          v_we      = 1'b1;
          v_waddr   = vcnt_m2[ADDR_W-1:0];
          v_wdata   = alu_res;
          vcnt_next = vcnt_m1;
          if (alu_rsp.divzero) begin
            err_next = note_err(err, ST_DIVZERO);
          end
          state_next = S_OP_RD;
        end
      end
      S_FIN_RD: begin
        v_raddr    = '0;
        state_next = S_FIN_WT;
      end
      S_FIN_WT: begin
        v_raddr = '0;
        if (fin_fire) begin
          out_valid_next  = 1'b1;
          out_result_next = (fin_err == ST_OK) ? RESULT_W'(signed'(v_rdata)) : '0;
          out_status_next = fin_err;
          ocnt_next       = '0;
          vcnt_next       = '0;
          err_next        = ST_OK;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ocnt      <= '0;
      vcnt      <= '0;
      err       <= ST_OK;
      tok_end   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ocnt      <= ocnt_next;
      vcnt      <= vcnt_next;
      err       <= err_next;
      tok_end   <= tok_end_next;
      out_valid <= out_valid_next;
    end
    tok_op     <= tok_op_next;
    b_reg      <= b_reg_next;
    out_result <= out_result_next;
    out_status <= out_status_next;
  end

  assign tok.ready  = (state == S_IDLE);
  assign res.valid  = out_valid;
  assign res.result = out_result;
  assign res.status = out_status;

  iee_ram #(.WIDTH(OP_W), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  iee_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  iee_alu #(.VALUE_WIDTH(W)) u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (v_rdata),
    .b   (b_reg),
    .rsp (alu_rsp),
    .res (alu_res)
  );

  // counts never pass the stack depth
  `IEE_ASSERT_IMPLY(a_vcnt_bound, clk, rst, 1'b1, vcnt <= CNT_W'(STACK_DEPTH))
  `IEE_ASSERT_IMPLY(a_ocnt_bound, clk, rst, 1'b1, ocnt <= CNT_W'(STACK_DEPTH))
  // the unit answers only while the sequencer waits for it
  `IEE_ASSERT_IMPLY(a_alu_done_wait, clk, rst, alu_rsp.done, state == S_ALU)
  // end of expression leaves everything empty
  `IEE_ASSERT_NEXT(a_clear_after_end, clk, rst, fin_fire,
                   vcnt == '0 && ocnt == '0 && err == ST_OK && out_valid)

endmodule

`default_nettype wire
